### rtl/ssiv_pkg.sv
package ssiv_pkg;

    // Length of one invert window in phase units.
    localparam int unsigned WIN_UNITS = 704;

    // Width of the stored phase accumulator.
    localparam int unsigned PHASE_W = 21;

    // Centre value of an unsigned 8-bit sample.
    localparam logic [7:0] SAMPLE_CENTRE = 8'd128;

    // Volume code that leaves the sample unscaled.
    localparam logic [2:0] VOL_FULL = 3'd7;

    // 704 = 64 * 11: after a shift by 6 the remainder of the division is by 11.
    // The reciprocal ceil(2^16 / 11) is exact for dividends below 2^15.
    localparam int unsigned DIV_SHIFT = 6;
    localparam logic [12:0] DIV11_RECIP = 13'd5958;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_LOOP,
        S_TAIL,
        S_MUL,
        S_DIV,
        S_QUOT,
        S_VOL,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decide;
        logic step;
        logic tail;
        logic mul;
        logic div;
        logic quot;
        logic vol;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic period_zero;
        logic in_window;
        logic loop_done;
        logic out_busy;
    } t_dp_sts;

    // Volume multiplier table.
    function automatic logic [15:0] vol_scale(input logic [2:0] vol);
        logic [15:0] s;
        case (vol)
            3'd0:    s = 16'd8192;
            3'd1:    s = 16'd9362;
            3'd2:    s = 16'd10922;
            3'd3:    s = 16'd13107;
            3'd4:    s = 16'd16384;
            3'd5:    s = 16'd21845;
            3'd6:    s = 16'd32768;
            default: s = 16'd0;
        endcase
        return s;
    endfunction

    // Volume offset table.
    function automatic logic [6:0] vol_bias(input logic [2:0] vol);
        logic [6:0] b;
        case (vol)
            3'd0:    b = 7'd112;
            3'd1:    b = 7'd110;
            3'd2:    b = 7'd107;
            3'd3:    b = 7'd103;
            3'd4:    b = 7'd96;
            3'd5:    b = 7'd86;
            3'd6:    b = 7'd64;
            default: b = 7'd0;
        endcase
        return b;
    endfunction

endpackage

### rtl/ssiv_ctrl.sv
module ssiv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ssiv_pkg::t_dp_sts i_sts,
    output ssiv_pkg::t_dp_cmd o_cmd
);
    import ssiv_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (!i_sts.period_zero && i_sts.in_window) begin
                    n_state = S_LOOP;
                end else begin
                    n_state = S_VOL;
                end
            end
            S_LOOP: begin
                o_cmd.step = 1'b1;
                if (i_sts.loop_done) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_QUOT;
            end
            S_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state    = S_VOL;
            end
            S_VOL: begin
                o_cmd.vol = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/ssiv_dp.sv
module ssiv_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssiv_pkg::t_dp_cmd i_cmd,
    output ssiv_pkg::t_dp_sts o_sts,
    input  logic [7:0]        i_sample_in,
    input  logic [15:0]       i_invert_period,
    input  logic              i_sound_off,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_wdata,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_sample_out
);
    import ssiv_pkg::*;

    // Control and carried state.
    logic [2:0]         r_volume;
    logic [PHASE_W-1:0] r_phase;
    logic               r_level;
    logic               r_out_valid;

    // Per-request working registers.
    logic [7:0]         r_x;
    logic [PHASE_W-1:0] r_incr;
    logic               r_off;
    logic [9:0]         r_last;
    logic [9:0]         r_on;
    logic [17:0]        r_prod;
    logic [24:0]        r_quot;
    logic [23:0]        r_vprod;
    logic [7:0]         r_out;

    logic [PHASE_W-1:0] n_incr;
    logic [PHASE_W:0]   n_phase_sum;
    logic [9:0]         w_gap;
    logic [9:0]         w_tail_gap;
    logic [7:0]         n_result;

    // Increment is period * 20, built from two shifts.
    assign n_incr = PHASE_W'({i_invert_period, 4'b0}) + PHASE_W'({i_invert_period, 2'b0});

    // One crossing of the phase loop.
    assign n_phase_sum = {1'b0, r_phase} + {1'b0, r_incr};
    assign w_gap       = r_phase[9:0] - r_last;
    assign w_tail_gap  = 10'(WIN_UNITS) - r_last;

    // Final volume stage.
    assign n_result = (r_volume != VOL_FULL)
                    ? r_vprod[23:16] + {1'b0, vol_bias(r_volume)}
                    : r_x;

    // Status towards the controller.
    assign o_sts.period_zero = (r_incr == '0);
    assign o_sts.in_window   = (r_phase < PHASE_W'(WIN_UNITS));
    assign o_sts.loop_done   = (n_phase_sum >= (PHASE_W+1)'(WIN_UNITS));
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // Volume register, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOL_FULL;
        end else if (i_cfg_we) begin
            r_volume <= i_cfg_wdata;
        end
    end

    // Phase accumulator and square-wave level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_level <= 1'b0;
        end else if (i_cmd.decide) begin
            if (!o_sts.period_zero && !o_sts.in_window) begin
                r_phase <= r_phase - PHASE_W'(WIN_UNITS);
            end
        end else if (i_cmd.step) begin
            r_level <= ~r_level;
            r_phase <= n_phase_sum[PHASE_W-1:0];
        end else if (i_cmd.tail) begin
            r_phase <= r_phase - PHASE_W'(WIN_UNITS);
        end
    end

    // Sample path: gating, division by the window and volume product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample_in;
            r_incr <= n_incr;
            r_off  <= i_sound_off;
        end
        if (i_cmd.decide) begin
            if (o_sts.period_zero) begin
                if (r_off) begin
                    r_x <= SAMPLE_CENTRE;
                end
            end else if (o_sts.in_window) begin
                r_on   <= '0;
                r_last <= '0;
            end else if (r_level) begin
                r_x <= '0;
            end
        end
        if (i_cmd.step) begin
            if (!r_level) begin
                r_on <= r_on + w_gap;
            end
            r_last <= r_phase[9:0];
        end
        if (i_cmd.tail && !r_level) begin
            r_on <= r_on + w_tail_gap;
        end
        if (i_cmd.mul) begin
            r_prod <= 18'(r_x) * 18'(r_on);
        end
        if (i_cmd.div) begin
            r_quot <= r_prod[17:DIV_SHIFT] * DIV11_RECIP;
        end
        if (i_cmd.quot) begin
            r_x <= r_quot[23:16];
        end
        if (i_cmd.vol) begin
            r_vprod <= r_x * vol_scale(r_volume);
        end
        if (i_cmd.emit) begin
            r_out <= n_result;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The on portion never exceeds the window.
    a_on_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step || i_cmd.tail) |-> (r_on <= 10'(WIN_UNITS)))
        else $error("on portion exceeds window");

    // Inside the loop the previous crossing never lies ahead of the phase.
    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (PHASE_W'(r_last) <= r_phase))
        else $error("crossing order broken");

    // The loop only ends once the phase has left the window.
    a_tail_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tail |-> (r_phase >= PHASE_W'(WIN_UNITS)))
        else $error("window end before phase left window");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_out_valid && !i_out_ready))
        else $error("result overwritten");

endmodule

### rtl/sound_sample_invert_volume_top.sv
// Square-wave invert and volume stage for an 8-bit sound stream.
//
// Input channel (i_in_valid / o_in_ready): one request carries a raw sample,
// the invert timer period and the sound-off flag. Output channel
// (o_out_valid / i_out_ready): exactly one processed sample per request,
// in order. The volume register is written through i_cfg_we / i_cfg_wdata.
//
// One request is worked on at a time: decide and volume, then the result
// register, when the period is zero or the phase is past the window, else
// decide, a phase loop of n crossings (1 to 36, one crossing per cycle),
// tail, multiply, divide, quotient and volume; the block is ready again in
// the cycle after the result is written. The phase loop sets the rate.
//
// Reset (synchronous, active low) clears the phase and level, sets the
// volume to 7 and empties the result register. When the receiver stalls,
// the result waits in its register; the next request is still accepted and
// worked on, and is held in its last step until the register is free.
module sound_sample_invert_volume_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_sample_in,
    input  logic [15:0] i_invert_period,
    input  logic        i_sound_off,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_sample_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata
);
    import ssiv_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    ssiv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and state.
    ssiv_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_sample_in     (i_sample_in),
        .i_invert_period (i_invert_period),
        .i_sound_off     (i_sound_off),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_out    (o_sample_out)
    );

endmodule
